// ----- rtl/spt_pkg.sv -----
// Package for the sorted proximity table: sizes, operation and register codes,
// and the structs passed between the top level and the table cells.
// No dependencies.
`timescale 1ns / 1ps

package spt_pkg;

   // Table geometry and field widths
   localparam int TABLE_DEPTH   = 1024;
   localparam int POSITION_BITS = 24;
   localparam int DIST_BITS     = 16;
   localparam int COUNT_BITS    = $clog2(TABLE_DEPTH + 1);
   localparam int DIFF_BITS     = (POSITION_BITS > DIST_BITS) ? POSITION_BITS : DIST_BITS;

   // Hit reduction: near flags are ORed in groups, then the group flags are ORed
   localparam int GROUP_SIZE  = 32;
   localparam int NUM_GROUPS  = (TABLE_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int PADDED_BITS = NUM_GROUPS * GROUP_SIZE;

   // Distances, in 1/16 m units
   localparam logic [DIST_BITS-1:0] ADD_DIST          = DIST_BITS'(16);
   localparam logic [DIST_BITS-1:0] LOOKUP_DIST_RESET = DIST_BITS'(1600);

   // Operation codes
   localparam logic FUNC_LOOKUP = 1'b0;
   localparam logic FUNC_ADD    = 1'b1;

   // Register port: byte address, registers on 32-bit words
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [CSR_ADDR_BITS-3:0] CSR_IDX_LOOKUP_MAX_DIST = '0;

   // What every cell sees of the request under way
   typedef struct packed {
      logic [POSITION_BITS-1:0] position;
      logic [DIST_BITS-1:0]     max_gap;
      logic                     shift_en;
   } spt_query_type;

   // What a cell hands to its right-hand neighbour
   typedef struct packed {
      logic [POSITION_BITS-1:0] value;
      logic                     greater;
   } spt_link_type;

endpackage

// ----- rtl/spt_cell.sv -----
// One cell of the sorted position chain: holds one entry, flags it near the request,
// and takes its left neighbour's entry or the new position when an insert shifts.
// Depends on spt_pkg.
`timescale 1ns / 1ps

module spt_cell
   import spt_pkg::*;
(
   input  logic          clock,
   input  spt_query_type query,
   input  logic          occupied,
   input  spt_link_type  prev_link,
   output spt_link_type  link,
   output logic          near
);

   logic [POSITION_BITS-1:0] value_ff;
   logic [POSITION_BITS-1:0] value_in;
   logic                     near_ff;
   logic                     near_in;
   logic [POSITION_BITS-1:0] diff;
   logic                     above;
   logic                     greater;

   // Absolute distance between the stored entry and the requested position
   always_comb begin
      above = value_ff > query.position;
      if (above) begin
         diff = value_ff - query.position;
      end else begin
         diff = query.position - value_ff;
      end
      near_in = occupied && (DIFF_BITS'(diff) < DIFF_BITS'(query.max_gap));
   end

   // An empty cell counts as holding a value above every position
   assign greater = !occupied || above;

   // Insert: every cell above the new position moves one place to the right
   always_comb begin
      value_in = value_ff;
      if (query.shift_en && greater) begin
         if (prev_link.greater) begin
            value_in = prev_link.value;
         end else begin
            value_in = query.position;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      near_ff  <= near_in;
   end

   assign link = '{value: value_ff, greater: greater};
   assign near = near_ff;

endmodule

// ----- rtl/spt_hit_tree.sv -----
// Registered OR tree that folds the near flags of all cells into one hit flag
// through a group register and a hit register. Depends on spt_pkg.
`timescale 1ns / 1ps

module spt_hit_tree
   import spt_pkg::*;
(
   input  logic                   clock,
   input  logic [TABLE_DEPTH-1:0] near,
   output logic                   hit
);

   logic [PADDED_BITS-1:0] padded;
   logic [NUM_GROUPS-1:0]  group_ff;
   logic [NUM_GROUPS-1:0]  group_in;
   logic                   hit_ff;
   logic                   hit_in;

   // Pad the flags to whole groups with zeros
   assign padded = PADDED_BITS'(near);

   // First level: one OR per group of cells
   for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_group
      assign group_in[g] = |padded[g*GROUP_SIZE +: GROUP_SIZE];
   end

   // Second level: OR of the group flags
   assign hit_in = |group_ff;

   always_ff @(posedge clock) begin
      group_ff <= group_in;
      hit_ff   <= hit_in;
   end

   assign hit = hit_ff;

endmodule

// ----- rtl/sorted_proximity_table_top.sv -----
// Top level of the sorted proximity table: request control, register port and the
// chain of table cells with its hit tree. Depends on spt_pkg, spt_cell, spt_hit_tree.
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Contents
// req_      in         req_valid/req_stall  func, position
// rsp_      out        rsp_valid/rsp_stall  found, inserted, table_full, entry_count
// csr_      in/out     APB-style, pready=1  lookup_max_dist at byte address 0
//
// A request passes through the probe state, which registers the near flags of all
// cells, the group and merge states of the OR tree, and the decide state, which
// decides and, on an insert, shifts the cell chain; no new request is accepted
// until the control is back in idle.
// Reset clears entry count, state and response valid, and presets the distance
// register; cells need no clearing, as only cells below the count are ever looked at.
// A stalled response is held in the output register; the next request may be
// accepted meanwhile and waits in its decide cycle until the response is taken.

module sorted_proximity_table_top
   import spt_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // Request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_func,
   input  logic [POSITION_BITS-1:0] req_position,
   // Response channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_found,
   output logic                     rsp_inserted,
   output logic                     rsp_table_full,
   output logic [COUNT_BITS-1:0]    rsp_entry_count,
   // Register port
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROBE,
      ST_GROUP,
      ST_MERGE,
      ST_DECIDE
   } state_type;

   state_type                state_ff;
   logic                     func_ff;
   logic [POSITION_BITS-1:0] position_ff;
   logic [DIST_BITS-1:0]     dist_ff;
   logic [COUNT_BITS-1:0]    count_ff;
   logic [DIST_BITS-1:0]     lookup_dist_ff;
   logic                     rsp_valid_ff;
   logic                     rsp_found_ff;
   logic                     rsp_inserted_ff;
   logic                     rsp_table_full_ff;
   logic [COUNT_BITS-1:0]    rsp_entry_count_ff;

   logic                     req_accept;
   logic                     out_free;
   logic                     hit;
   logic                     table_is_full;
   logic                     do_insert;
   logic                     csr_write;
   logic [CSR_ADDR_BITS-3:0] csr_word;
   spt_query_type            query;
   logic [TABLE_DEPTH-1:0]   occupied;
   logic [TABLE_DEPTH-1:0]   near;
   spt_link_type             link      [TABLE_DEPTH];
   spt_link_type             prev_link [TABLE_DEPTH];

   // Handshake and decision terms
   assign req_stall     = state_ff != ST_IDLE;
   assign req_accept    = req_valid && !req_stall;
   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign table_is_full = count_ff == COUNT_BITS'(TABLE_DEPTH);
   assign do_insert     = (state_ff == ST_DECIDE) && out_free && (func_ff == FUNC_ADD)
                          && !hit && !table_is_full;

   assign query = '{position: position_ff, max_gap: dist_ff, shift_en: do_insert};

   // Cell chain: cell 0 sees a left neighbour that is never above the position
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      assign occupied[i] = COUNT_BITS'(i) < count_ff;
      if (i == 0) begin : g_first
         assign prev_link[i] = '{value: '0, greater: 1'b0};
      end else begin : g_rest
         assign prev_link[i] = link[i-1];
      end
      spt_cell u_cell (
         .clock     (clock),
         .query     (query),
         .occupied  (occupied[i]),
         .prev_link (prev_link[i]),
         .link      (link[i]),
         .near      (near[i])
      );
   end

   spt_hit_tree u_hit_tree (
      .clock (clock),
      .near  (near),
      .hit   (hit)
   );

   // Request sequencing, entry count and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_DECIDE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  func_ff     <= req_func;
                  position_ff <= req_position;
                  dist_ff     <= (req_func == FUNC_ADD) ? ADD_DIST : lookup_dist_ff;
                  state_ff    <= ST_PROBE;
               end
            end
            ST_PROBE: state_ff <= ST_GROUP;
            ST_GROUP: state_ff <= ST_MERGE;
            ST_MERGE: state_ff <= ST_DECIDE;
            ST_DECIDE: begin
               if (out_free) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_found_ff       <= hit;
                  rsp_inserted_ff    <= do_insert;
                  rsp_table_full_ff  <= (func_ff == FUNC_ADD) && !hit && table_is_full;
                  rsp_entry_count_ff <= count_ff + COUNT_BITS'(do_insert);
                  if (do_insert) begin
                     count_ff <= count_ff + COUNT_BITS'(1);
                  end
                  state_ff <= ST_IDLE;
               end else if (rsp_valid_ff && !rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Register port
   assign csr_word   = csr_paddr[CSR_ADDR_BITS-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lookup_dist_ff <= LOOKUP_DIST_RESET;
      end else if (csr_write && (csr_word == CSR_IDX_LOOKUP_MAX_DIST)) begin
         lookup_dist_ff <= csr_pwdata[DIST_BITS-1:0];
      end
   end

   always_comb begin
      unique case (csr_word)
         CSR_IDX_LOOKUP_MAX_DIST: csr_prdata = CSR_DATA_BITS'(lookup_dist_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   // Response outputs
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_inserted    = rsp_inserted_ff;
   assign rsp_table_full  = rsp_table_full_ff;
   assign rsp_entry_count = rsp_entry_count_ff;

endmodule

// ----- tb/tb_sorted_proximity_table_top.sv -----
// Self-checking testbench for sorted_proximity_table_top: a scoreboard class keeps a
// sorted copy of the table and predicts every response; plain tasks drive the ports.
// Depends on spt_pkg and sorted_proximity_table_top.
`timescale 1ns / 1ps

module tb_sorted_proximity_table_top;
   import spt_pkg::*;

   localparam longint POS_MAX     = (64'd1 << POSITION_BITS) - 1;
   localparam int     CYCLE_LIMIT = 600000;
   localparam int     SETTLE      = 12;
   localparam int     LONG_HOLD   = 400;

   // Expected contents of one response
   typedef struct packed {
      logic                  found;
      logic                  inserted;
      logic                  table_full;
      logic [COUNT_BITS-1:0] entry_count;
   } outcome_type;

   // Scoreboard: a sorted copy of the table, the hit distance and the responses due.
   class table_tracker;
      logic [POSITION_BITS-1:0] slots[TABLE_DEPTH];
      int unsigned              stored;
      logic [DIST_BITS-1:0]     lookup_dist;
      outcome_type              outcomes_due[$];
      int unsigned              mismatches;

      function new();
         stored      = 0;
         lookup_dist = LOOKUP_DIST_RESET;
         mismatches  = 0;
      endfunction

      task report(string msg);
         $display("%0t: mismatch: %s", $realtime, msg);
         mismatches++;
      endtask

      function bit is_near(int idx, logic [POSITION_BITS-1:0] pos,
                           logic [DIST_BITS-1:0] max_gap);
         longint diff;
         diff = (slots[idx] > pos) ? longint'(slots[idx]) - longint'(pos)
                                   : longint'(pos) - longint'(slots[idx]);
         return diff < longint'(max_gap);
      endfunction

      // Binary search over the stored range; a single entry decides on its own.
      function bit search_table(logic [POSITION_BITS-1:0] pos,
                                logic [DIST_BITS-1:0] max_gap);
         int lo;
         int hi;
         int mid;
         lo = 0;
         hi = int'(stored) - 1;
         while (lo <= hi) begin
            if (lo == hi)
               return is_near(lo, pos, max_gap);
            mid = lo + (hi - lo) / 2;
            if (is_near(mid, pos, max_gap))
               return 1'b1;
            if (slots[mid] < pos)
               lo = mid + 1;
            else
               hi = mid;
         end
         return 1'b0;
      endfunction

      // Applies an accepted request to the table copy and queues its response.
      function void note_request(logic func, logic [POSITION_BITS-1:0] pos);
         outcome_type res;
         int          i;
         res = '0;
         if (func == FUNC_LOOKUP) begin
            res.found = search_table(pos, lookup_dist);
         end else if (search_table(pos, ADD_DIST)) begin
            res.found = 1'b1;
         end else if (stored >= TABLE_DEPTH) begin
            res.table_full = 1'b1;
         end else begin
            i = stored;
            while (i > 0 && slots[i-1] > pos) begin
               slots[i] = slots[i-1];
               i--;
            end
            slots[i]     = pos;
            stored++;
            res.inserted = 1'b1;
         end
         res.entry_count = COUNT_BITS'(stored);
         outcomes_due = {outcomes_due, res};
      endfunction

      // Compares an accepted response with the oldest one due.
      task check_response(outcome_type got);
         outcome_type want;
         if (outcomes_due.size() == 0) begin
            report("response arrived with no request outstanding");
         end else begin
            want = outcomes_due.pop_front();
            if (got.found !== want.found)
               report($sformatf("found %b, expected %b", got.found, want.found));
            if (got.inserted !== want.inserted)
               report($sformatf("inserted %b, expected %b", got.inserted, want.inserted));
            if (got.table_full !== want.table_full)
               report($sformatf("table_full %b, expected %b",
                                got.table_full, want.table_full));
            if (got.entry_count !== want.entry_count)
               report($sformatf("entry_count %0d, expected %0d",
                                got.entry_count, want.entry_count));
         end
      endtask
   endclass

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic                     req_func;
   logic [POSITION_BITS-1:0] req_position;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic                     rsp_found;
   logic                     rsp_inserted;
   logic                     rsp_table_full;
   logic [COUNT_BITS-1:0]    rsp_entry_count;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   table_tracker tracker;
   int unsigned  burst_left;
   int unsigned  cycle_count;
   logic [31:0]  stall_cycle;
   int unsigned  hold_left;
   bit           want_long_hold;
   bit           long_hold_done;

   sorted_proximity_table_top dut (.*);

   // Free-running clock, 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Abandon the run if it hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Receiver: switches stall pattern on a free-running counter, with one long hold-off
   // that starts while the sender is kept waiting with a request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall      <= 1'b0;
         stall_cycle    = '0;
         hold_left      = 0;
         long_hold_done = 1'b0;
      end else begin
         stall_cycle++;
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (want_long_hold && !long_hold_done && req_valid && req_stall) begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD - 1;
            rsp_stall      <= 1'b1;
         end else begin
            case (stall_cycle[9:8])
               2'd0: rsp_stall <= 1'b0;
               2'd1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2'd2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= stall_cycle[2];
            endcase
         end
      end
   end

   // Response monitor.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_response({rsp_found, rsp_inserted, rsp_table_full, rsp_entry_count});
   end

   // Offers one request, waits until it is taken, then idles as the burst dictates.
   task automatic offer(logic func, logic [POSITION_BITS-1:0] pos);
      int unsigned gap;
      req_valid    <= 1'b1;
      req_func     <= func;
      req_position <= pos;
      do @(posedge clock); while (req_stall);
      tracker.note_request(func, pos);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   // Stops offering and lets every outstanding response drain.
   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.outcomes_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Writes the hit distance, then reads it back.
   task automatic write_lookup_dist(logic [DIST_BITS-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {CSR_IDX_LOOKUP_MAX_DIST, 2'b00};
      csr_pwdata  <= CSR_DATA_BITS'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      tracker.lookup_dist = value;
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      if (csr_prdata !== CSR_DATA_BITS'(value))
         tracker.report($sformatf("lookup_max_dist reads %0h, expected %0h",
                                  csr_prdata, value));
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // One setting of the distance, then random requests, nearly half of them aimed at
   // stored entries and at the edges of the hit distance.
   task automatic run_phase(logic [DIST_BITS-1:0] max_gap, int unsigned count);
      int     roll;
      longint base;
      longint offset;
      longint pos;
      logic   func;
      drain();
      write_lookup_dist(max_gap);
      repeat (count) begin
         roll = $urandom_range(0, 99);
         base = (tracker.stored > 0)
                ? longint'(tracker.slots[$urandom_range(0, tracker.stored - 1)])
                : longint'($urandom_range(0, POS_MAX));
         case ($urandom_range(0, 5))
            0: offset = longint'(max_gap) - 1;
            1: offset = longint'(max_gap);
            2: offset = longint'(max_gap) + 1;
            3: offset = $urandom_range(0, 2 * max_gap + 2);
            4: offset = 0;
            default: offset = $urandom_range(0, 40);
         endcase
         if ($urandom_range(0, 1))
            offset = -offset;
         if (roll < 30) begin
            func = FUNC_ADD;
            pos  = $urandom_range(0, POS_MAX);
         end else if (roll < 45) begin
            func = FUNC_ADD;
            pos  = base + $urandom_range(0, 40) - 20;
         end else if (roll < 75) begin
            func = FUNC_LOOKUP;
            pos  = base + offset;
         end else if (roll < 90) begin
            func = FUNC_LOOKUP;
            pos  = $urandom_range(0, POS_MAX);
         end else begin
            func = ($urandom_range(0, 1) == 0) ? FUNC_LOOKUP : FUNC_ADD;
            pos  = $urandom_range(0, 1) ? $urandom_range(0, 64)
                                        : POS_MAX - $urandom_range(0, 64);
         end
         if (pos < 0)
            pos = 0;
         if (pos > POS_MAX)
            pos = POS_MAX;
         offer(func, POSITION_BITS'(pos));
      end
   endtask

   // Main sequence.
   initial begin
      tracker        = new();
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_func       = FUNC_LOOKUP;
      req_position   = '0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      burst_left     = 0;
      cycle_count    = 0;
      want_long_hold = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset distance: empty table, add hits and misses at the
      // one-metre edge, field extremes and lookups either side of the hit distance.
      offer(FUNC_LOOKUP, '0);
      offer(FUNC_LOOKUP, POSITION_BITS'(POS_MAX));
      offer(FUNC_ADD, 24'd1000);
      offer(FUNC_ADD, 24'd1000);
      offer(FUNC_ADD, 24'd1015);
      offer(FUNC_ADD, 24'd1016);
      offer(FUNC_ADD, 24'd984);
      offer(FUNC_ADD, '0);
      offer(FUNC_ADD, POSITION_BITS'(POS_MAX));
      offer(FUNC_ADD, POSITION_BITS'(POS_MAX - 15));
      offer(FUNC_ADD, POSITION_BITS'(POS_MAX - 16));
      offer(FUNC_ADD, 24'd500);
      offer(FUNC_ADD, 24'h800000);
      offer(FUNC_ADD, 24'h555555);
      offer(FUNC_ADD, 24'hAAAAAA);
      offer(FUNC_LOOKUP, 24'd2615);
      offer(FUNC_LOOKUP, 24'd2616);
      offer(FUNC_LOOKUP, POSITION_BITS'(POS_MAX - 1599));
      offer(FUNC_LOOKUP, 24'd555);
      offer(FUNC_LOOKUP, 24'h800000 + 24'd1599);
      offer(FUNC_LOOKUP, 24'h800000 + 24'd1600);
      offer(FUNC_LOOKUP, 24'h400000);

      // Distance settings, extremes included; the long receiver hold-off falls in
      // the widest setting.
      run_phase('0, 70);
      want_long_hold = 1'b1;
      run_phase('1, 70);
      run_phase(16'd1, 70);
      run_phase(ADD_DIST, 70);
      run_phase(DIST_BITS'($urandom_range(2, 16'hFFFE)), 80);
      run_phase(LOOKUP_DIST_RESET, 90);

      // Adds at any, the lowest and the top entry; lookups at one and the extremes.
      offer(FUNC_ADD, tracker.slots[$urandom_range(0, tracker.stored - 1)]);
      offer(FUNC_ADD, tracker.slots[0]);
      offer(FUNC_ADD, tracker.slots[tracker.stored - 1]);
      offer(FUNC_LOOKUP, tracker.slots[$urandom_range(0, tracker.stored - 1)]);
      offer(FUNC_LOOKUP, '0);
      offer(FUNC_LOOKUP, POSITION_BITS'(POS_MAX));
      drain();

      if (tracker.mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
